/* src/rbol_pkg.sv */
// shared types and constants for the ring buffer offset lookup
package rbol_pkg;

    localparam int SLOT_COUNT = 10;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 16;
    localparam int OFFS_W   = 20;
    localparam int SLOTNUM_W = 4;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_FIND = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_ADDED   = 2'd0,
        STAT_FOUND   = 2'd1,
        STAT_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [HANDLE_W-1:0] entry_handle;
        logic [SIZE_W-1:0]   entry_size;
        logic [OFFS_W-1:0]   char_pos;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [SLOTNUM_W-1:0] slot_index;
        logic [HANDLE_W-1:0]  found_handle;
        logic [SIZE_W-1:0]    byte_offset;
    } t_out_item;

    // one stored entry, moved one cell further on every add
    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [SIZE_W-1:0]     size;
        logic [SLOT_IDX_W-1:0] slot;
    } t_entry;

    // search token, moved one cell towards the newest entry on every step
    typedef struct packed {
        logic                  found;
        logic [OFFS_W-1:0]     rem;
        logic [SLOT_IDX_W-1:0] slot;
        logic [HANDLE_W-1:0]   handle;
        logic [SIZE_W-1:0]     boff;
    } t_token;

endpackage

/* src/rbol_cell.sv */
// one cell of the entry chain: holds an entry and processes the search token
module rbol_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  rbol_pkg::t_entry i_ent,
    output rbol_pkg::t_entry o_ent,
    input  logic            i_step,
    input  rbol_pkg::t_token i_tok,
    output rbol_pkg::t_token o_tok
);

    rbol_pkg::t_entry r_ent;
    rbol_pkg::t_token r_tok;
    rbol_pkg::t_token n_tok;
    logic             w_hit;

    // an empty cell has zero size, so the token passes it untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else if (i_shift) begin
            r_ent <= i_ent;
        end
    end

    assign w_hit = !i_tok.found &&
                   (i_tok.rem < {{(rbol_pkg::OFFS_W - rbol_pkg::SIZE_W){1'b0}}, r_ent.size});

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found  = 1'b1;
            n_tok.slot   = r_ent.slot;
            n_tok.handle = r_ent.handle;
            n_tok.boff   = i_tok.rem[rbol_pkg::SIZE_W-1:0];
        end else if (!i_tok.found) begin
            n_tok.rem = i_tok.rem
                        - {{(rbol_pkg::OFFS_W - rbol_pkg::SIZE_W){1'b0}}, r_ent.size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_tok <= n_tok;
        end
    end

    assign o_ent = r_ent;
    assign o_tok = r_tok;

endmodule

/* src/ring_buffer_offset_lookup.sv */
// top level of the ring buffer offset lookup: control, cell chain and result register
//
// A ring of SLOT_COUNT entries (handle and byte length) kept as a chain of
// cells ordered by age: cell 0 holds the newest entry, the last cell the
// oldest. An add item shifts every entry one cell along and puts the new one
// into cell 0, so once the ring is full the oldest entry drops out of the
// end; each cell remembers the ring slot number its entry was written to.
// A find item launches a search token into the oldest cell; the token moves
// one cell per cycle towards the newest, subtracting each entry's length
// from the remaining offset until it lands inside an entry. Empty cells and
// zero-length entries are passed over. One item is handled at a time: an
// add passes through the FLUSH state into the result register, a find is
// loaded once its token has walked the cell chain down to cell 0. The
// input is ready again in the same cycle that the result register first
// presents the result. A finished item waits in place for the result
// register to be emptied before it is loaded. Input ready is held low
// during reset. Reset clears every cell to an empty entry.
module ring_buffer_offset_lookup (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rbol_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rbol_pkg::t_out_item o_out_data
);

    localparam int N = rbol_pkg::SLOT_COUNT;
    localparam int W = rbol_pkg::SLOT_IDX_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [W-1:0]        r_cnt, n_cnt;
    logic [W-1:0]        r_wr_idx, n_wr_idx;
    logic                r_is_add, n_is_add;
    logic                r_out_valid, n_out_valid;
    rbol_pkg::t_out_item r_out_data, n_out_data;

    logic                w_accept;
    logic                w_shift;
    logic                w_step;
    logic                w_res_ready;
    logic                w_out_free;
    rbol_pkg::t_entry    w_new_ent;
    rbol_pkg::t_token    w_new_tok;
    rbol_pkg::t_entry    w_ent [N];
    rbol_pkg::t_token    w_tok [N];

    // handshake
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // an add shifts the chain, a find launches the token
    assign w_shift = w_accept && (i_in_data.cmd == rbol_pkg::CMD_ADD);
    assign w_step  = (w_accept && (i_in_data.cmd == rbol_pkg::CMD_FIND))
                     || ((r_state == S_WALK) && (r_cnt != '0));

    // token has reached cell 0 once the walk counter runs out
    assign w_res_ready = (r_state == S_FLUSH) || ((r_state == S_WALK) && (r_cnt == '0));

    always_comb begin
        w_new_ent.handle = i_in_data.entry_handle;
        w_new_ent.size   = i_in_data.entry_size;
        w_new_ent.slot   = r_wr_idx;

        w_new_tok        = '0;
        w_new_tok.rem    = i_in_data.char_pos;
    end

    // cell chain: entries move up the index, the token moves down
    for (genvar k = 0; k < N; k++) begin : g_cell
        rbol_pkg::t_entry w_ent_in;
        rbol_pkg::t_token w_tok_in;

        if (k == 0) begin : g_first
            assign w_ent_in = w_new_ent;
        end else begin : g_mid_ent
            assign w_ent_in = w_ent[k-1];
        end

        if (k == N - 1) begin : g_last
            assign w_tok_in = w_new_tok;
        end else begin : g_mid_tok
            assign w_tok_in = w_tok[k+1];
        end

        rbol_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_ent   (w_ent_in),
            .o_ent   (w_ent[k]),
            .i_step  (w_step),
            .i_tok   (w_tok_in),
            .o_tok   (w_tok[k])
        );
    end

    // control and result register
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_wr_idx    = r_wr_idx;
        n_is_add    = r_is_add;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.cmd == rbol_pkg::CMD_ADD) begin
                        n_is_add = 1'b1;
                        n_state  = S_FLUSH;
                        // write slot wraps after the last one
                        if (r_wr_idx == W'(N - 1)) begin
                            n_wr_idx = '0;
                        end else begin
                            n_wr_idx = r_wr_idx + 1'b1;
                        end
                    end else begin
                        n_is_add = 1'b0;
                        n_cnt    = W'(N - 1);
                        n_state  = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else if (!w_out_free) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_res_ready && w_out_free) begin
            n_out_valid = 1'b1;
            n_state     = S_IDLE;
            n_out_data  = '0;
            if (r_is_add) begin
                n_out_data.status = rbol_pkg::STAT_ADDED;
            end else if (w_tok[0].found) begin
                n_out_data.status       = rbol_pkg::STAT_FOUND;
                n_out_data.slot_index   = rbol_pkg::SLOTNUM_W'(w_tok[0].slot);
                n_out_data.found_handle = w_tok[0].handle;
                n_out_data.byte_offset  = w_tok[0].boff;
            end else begin
                n_out_data.status = rbol_pkg::STAT_MISSING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wr_idx    <= '0;
            r_is_add    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wr_idx    <= n_wr_idx;
            r_is_add    <= n_is_add;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
